// ----- hw/rtl/accumulator_alu_with_flags_defines.svh -----
// Assertion macros for the accumulator ALU.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACCALU_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The signal must keep its value into the cycle after the antecedent.
`define ACCALU_ASSERT_HOLD(label, ante, sig, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> $stable(sig)) \
      else $error(msg);

`endif

// ----- hw/rtl/accalu_pkg.sv -----
// Package with the operation codes and flag type of the accumulator ALU.
package accalu_pkg;

   // Widths of the item fields.
   localparam int KindWidth = 5;
   localparam int DataWidth = 8;

   // Operation codes.
   localparam logic [KindWidth-1:0] KIND_ADD  = 5'd0;
   localparam logic [KindWidth-1:0] KIND_ADC  = 5'd1;
   localparam logic [KindWidth-1:0] KIND_SUB  = 5'd2;
   localparam logic [KindWidth-1:0] KIND_SBB  = 5'd3;
   localparam logic [KindWidth-1:0] KIND_AND  = 5'd4;
   localparam logic [KindWidth-1:0] KIND_XOR  = 5'd5;
   localparam logic [KindWidth-1:0] KIND_OR   = 5'd6;
   localparam logic [KindWidth-1:0] KIND_CMP  = 5'd7;
   localparam logic [KindWidth-1:0] KIND_INR  = 5'd8;
   localparam logic [KindWidth-1:0] KIND_DCR  = 5'd9;
   localparam logic [KindWidth-1:0] KIND_DAA  = 5'd10;
   localparam logic [KindWidth-1:0] KIND_RLC  = 5'd11;
   localparam logic [KindWidth-1:0] KIND_RRC  = 5'd12;
   localparam logic [KindWidth-1:0] KIND_RAL  = 5'd13;
   localparam logic [KindWidth-1:0] KIND_RAR  = 5'd14;
   localparam logic [KindWidth-1:0] KIND_CMA  = 5'd15;
   localparam logic [KindWidth-1:0] KIND_CMC  = 5'd16;
   localparam logic [KindWidth-1:0] KIND_STC  = 5'd17;
   localparam logic [KindWidth-1:0] KIND_LOAD = 5'd18;

   // Decimal adjust constants.
   localparam logic [DataWidth-1:0] DAA_LOW_CORR  = 8'h06;
   localparam logic [DataWidth-1:0] DAA_HIGH_CORR = 8'h60;
   localparam logic [3:0]           DAA_DIGIT_MAX = 4'd9;

   // Processor status flags.
   typedef struct packed {
      logic sign;
      logic zero;
      logic aux;
      logic parity;
      logic carry;
   } flags_type;

endpackage

// ----- hw/rtl/accumulator_alu_with_flags.sv -----
// Eight-bit accumulator ALU with sign, zero, auxiliary carry, parity and carry flags.
//
// Usage:
// - The request channel (req_valid/req_ready) carries one item: an operation
//   code req_kind and an operand byte req_operand.
// - The response channel (rsp_valid/rsp_ready) returns one item per request:
//   the produced byte, the accumulator and the five flags after the operation.
// - A request is captured in an input register; the ALU logic reads it from
//   there together with the accumulator and flags, and once the response
//   register is free or being taken, the result is written to it while the
//   state is updated. A request passes the input register and then the
//   response register before rsp_valid rises.
// - While the receiver does not stall, throughput is one item per cycle; the
//   accumulator and flags feed back through the single ALU pass, so each item
//   sees the state its predecessor left.
// - When the receiver stalls, the response register holds its item and the
//   input register takes one more request; ready then drops until the
//   response is taken.
// - Reset clears the accumulator, all flags and both valid bits.
module accumulator_alu_with_flags (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_kind,
   input  logic [7:0] req_operand,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result_value,
   output logic [7:0] rsp_acc_out,
   output logic       rsp_sign_out,
   output logic       rsp_zero_out,
   output logic       rsp_aux_out,
   output logic       rsp_parity_out,
   output logic       rsp_carry_out
);

`include "accumulator_alu_with_flags_defines.svh"

   // Input register.
   logic       in_valid_ff;
   logic [4:0] in_kind_ff;
   logic [7:0] in_operand_ff;

   // Architectural state.
   logic [7:0]            acc_ff;
   logic [7:0]            acc_in;
   accalu_pkg::flags_type flags_ff;
   accalu_pkg::flags_type flags_in;

   // Response register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_result_ff;
   logic [7:0] result_in;

   logic advance;
   logic blocked;
   logic side_item;

   // ALU internals.
   logic       sub_op;
   logic [7:0] add_b;
   logic       add_cin;
   logic [8:0] add_sum;
   logic [4:0] nib_sum;
   logic [7:0] szp_src;
   logic       szp_en;
   logic [7:0] daa_corr;
   logic       daa_high;
   logic [7:0] inc_val;
   logic [7:0] dec_val;

   // The item moves into the response register when that register is free or its item is taken.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Conditions watched by the checks at the end of the module.
   assign blocked   = in_valid_ff && rsp_valid_ff && !rsp_ready;
   assign side_item = advance && ((in_kind_ff == accalu_pkg::KIND_INR) ||
                                  (in_kind_ff == accalu_pkg::KIND_DCR));

   // Decimal adjust correction from the accumulator digits and flags.
   always_comb begin
      daa_corr = '0;
      daa_high = 1'b0;
      if (flags_ff.aux || (acc_ff[3:0] > accalu_pkg::DAA_DIGIT_MAX)) begin
         daa_corr = daa_corr | accalu_pkg::DAA_LOW_CORR;
      end
      if (flags_ff.carry || (acc_ff[7:4] > accalu_pkg::DAA_DIGIT_MAX) ||
          ((acc_ff[7:4] >= accalu_pkg::DAA_DIGIT_MAX) &&
           (acc_ff[3:0] > accalu_pkg::DAA_DIGIT_MAX))) begin
         daa_corr = daa_corr | accalu_pkg::DAA_HIGH_CORR;
         daa_high = 1'b1;
      end
   end

   // Shared adder operands; subtraction adds the complement.
   always_comb begin
      sub_op  = 1'b0;
      add_b   = in_operand_ff;
      add_cin = 1'b0;
      case (in_kind_ff)
         accalu_pkg::KIND_ADC: begin
            add_cin = flags_ff.carry;
         end
         accalu_pkg::KIND_SUB, accalu_pkg::KIND_CMP: begin
            sub_op  = 1'b1;
            add_b   = ~in_operand_ff;
            add_cin = 1'b1;
         end
         accalu_pkg::KIND_SBB: begin
            sub_op  = 1'b1;
            add_b   = ~in_operand_ff;
            add_cin = ~flags_ff.carry;
         end
         accalu_pkg::KIND_DAA: begin
            add_b = daa_corr;
         end
         default: begin
            add_cin = 1'b0;
         end
      endcase
   end

   assign add_sum = {1'b0, acc_ff} + {1'b0, add_b} + {8'd0, add_cin};
   assign nib_sum = {1'b0, acc_ff[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
   assign inc_val = in_operand_ff + 8'd1;
   assign dec_val = in_operand_ff - 8'd1;

   // Operation decode: next accumulator, flags and produced byte.
   always_comb begin
      acc_in    = acc_ff;
      flags_in  = flags_ff;
      szp_src   = acc_ff;
      szp_en    = 1'b0;
      result_in = '0;
      case (in_kind_ff)
         accalu_pkg::KIND_ADD, accalu_pkg::KIND_ADC,
         accalu_pkg::KIND_SUB, accalu_pkg::KIND_SBB: begin
            acc_in         = add_sum[7:0];
            flags_in.carry = add_sum[8] ^ sub_op;
            flags_in.aux   = nib_sum[4];
            szp_src        = add_sum[7:0];
            szp_en         = 1'b1;
         end
         accalu_pkg::KIND_CMP: begin
            flags_in.carry = add_sum[8] ^ sub_op;
            flags_in.aux   = nib_sum[4];
            szp_src        = add_sum[7:0];
            szp_en         = 1'b1;
         end
         accalu_pkg::KIND_AND: begin
            acc_in         = acc_ff & in_operand_ff;
            flags_in.carry = 1'b0;
            flags_in.aux   = acc_ff[3] | in_operand_ff[3];
            szp_src        = acc_ff & in_operand_ff;
            szp_en         = 1'b1;
         end
         accalu_pkg::KIND_XOR: begin
            acc_in         = acc_ff ^ in_operand_ff;
            flags_in.carry = 1'b0;
            flags_in.aux   = 1'b0;
            szp_src        = acc_ff ^ in_operand_ff;
            szp_en         = 1'b1;
         end
         accalu_pkg::KIND_OR: begin
            acc_in         = acc_ff | in_operand_ff;
            flags_in.carry = 1'b0;
            flags_in.aux   = 1'b0;
            szp_src        = acc_ff | in_operand_ff;
            szp_en         = 1'b1;
         end
         accalu_pkg::KIND_INR: begin
            flags_in.aux = (inc_val[3:0] == 4'd0);
            szp_src      = inc_val;
            szp_en       = 1'b1;
         end
         accalu_pkg::KIND_DCR: begin
            flags_in.aux = (in_operand_ff[3:0] != 4'd0);
            szp_src      = dec_val;
            szp_en       = 1'b1;
         end
         accalu_pkg::KIND_DAA: begin
            acc_in         = add_sum[7:0];
            flags_in.carry = flags_ff.carry | daa_high;
            flags_in.aux   = nib_sum[4];
            szp_src        = add_sum[7:0];
            szp_en         = 1'b1;
         end
         accalu_pkg::KIND_RLC: begin
            acc_in         = {acc_ff[6:0], acc_ff[7]};
            flags_in.carry = acc_ff[7];
         end
         accalu_pkg::KIND_RRC: begin
            acc_in         = {acc_ff[0], acc_ff[7:1]};
            flags_in.carry = acc_ff[0];
         end
         accalu_pkg::KIND_RAL: begin
            acc_in         = {acc_ff[6:0], flags_ff.carry};
            flags_in.carry = acc_ff[7];
         end
         accalu_pkg::KIND_RAR: begin
            acc_in         = {flags_ff.carry, acc_ff[7:1]};
            flags_in.carry = acc_ff[0];
         end
         accalu_pkg::KIND_CMA: begin
            acc_in = ~acc_ff;
         end
         accalu_pkg::KIND_CMC: begin
            flags_in.carry = ~flags_ff.carry;
         end
         accalu_pkg::KIND_STC: begin
            flags_in.carry = 1'b1;
         end
         accalu_pkg::KIND_LOAD: begin
            acc_in = in_operand_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase

      // Sign, zero and even parity from the produced byte.
      if (szp_en) begin
         flags_in.sign   = szp_src[7];
         flags_in.zero   = (szp_src == 8'd0);
         flags_in.parity = ~^szp_src;
      end

      // Increment and decrement report their own value, all else the accumulator.
      if (in_kind_ff == accalu_pkg::KIND_INR) begin
         result_in = inc_val;
      end else if (in_kind_ff == accalu_pkg::KIND_DCR) begin
         result_in = dec_val;
      end else begin
         result_in = acc_in;
      end
   end

   // Input register: valid under reset, payload only on capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_kind_ff    <= req_kind;
         in_operand_ff <= req_operand;
      end
   end

   // Accumulator and flags change only when an item passes the ALU.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         flags_ff <= '0;
      end else if (advance) begin
         acc_ff   <= acc_in;
         flags_ff <= flags_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_acc_out      = acc_ff;
   assign rsp_sign_out     = flags_ff.sign;
   assign rsp_zero_out     = flags_ff.zero;
   assign rsp_aux_out      = flags_ff.aux;
   assign rsp_parity_out   = flags_ff.parity;
   assign rsp_carry_out    = flags_ff.carry;

   // A full input stage is the only reason to refuse a request.
   `ACCALU_ASSERT_IMPLY(a_ready_low_full, !req_ready, blocked, "request refused unblocked")
   // The state must not move while no item passes the ALU.
   `ACCALU_ASSERT_HOLD(a_acc_hold, !advance, acc_ff, "accumulator changed without an item")
   `ACCALU_ASSERT_HOLD(a_flags_hold, !advance, flags_ff, "flags changed without an item")
   // Increment and decrement leave the accumulator as it was.
   `ACCALU_ASSERT_IMPLY(a_side_acc, side_item, acc_in == acc_ff, "inr or dcr changed acc")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the accumulator ALU: directed table, random items, predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Codes with no operation behind them: the block keeps its state.
   localparam logic [accalu_pkg::KindWidth-1:0] KIND_UNUSED_FIRST = 5'd19;
   localparam logic [accalu_pkg::KindWidth-1:0] KIND_UNUSED_LAST  = 5'd31;

   localparam int IDLE_PERCENT  = 18;
   localparam int STALL_PERCENT = 18;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int QUIET_FIRST   = 500;
   localparam int QUIET_LAST    = 700;
   localparam int DRAIN_CYCLES  = 8;

   // One result item as the block reports it.
   typedef struct packed {
      logic [accalu_pkg::DataWidth-1:0] value;
      logic [accalu_pkg::DataWidth-1:0] acc;
      accalu_pkg::flags_type            flags;
   } alu_result_type;

   // One row of the directed table; want is only used where fixed is set.
   typedef struct packed {
      logic [accalu_pkg::KindWidth-1:0] kind;
      logic [accalu_pkg::DataWidth-1:0] operand;
      logic                             fixed;
      alu_result_type                   want;
   } stim_row_type;

   localparam alu_result_type UNCHECKED = '0;
   localparam int NUM_DIRECTED = 24;

   // Flags in the typed-in rows read sign, zero, aux, parity, carry.
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      {accalu_pkg::KIND_LOAD, 8'hFF, 1'b1, 8'hFF, 8'hFF, 5'b00000},
      {accalu_pkg::KIND_ADD,  8'h01, 1'b1, 8'h00, 8'h00, 5'b01111},
      {accalu_pkg::KIND_ADC,  8'hFF, 1'b1, 8'h00, 8'h00, 5'b01111},
      {accalu_pkg::KIND_SBB,  8'h00, 1'b1, 8'hFF, 8'hFF, 5'b10011},
      {accalu_pkg::KIND_SUB,  8'hFF, 1'b1, 8'h00, 8'h00, 5'b01110},
      {accalu_pkg::KIND_CMP,  8'h01, 1'b1, 8'h00, 8'h00, 5'b10011},
      {accalu_pkg::KIND_LOAD, 8'hAA, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_AND,  8'h0F, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_XOR,  8'hFF, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_OR,   8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_INR,  8'hFF, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_DCR,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_LOAD, 8'h9A, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_DAA,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_LOAD, 8'h99, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_STC,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_DAA,  8'hFF, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_CMC,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_RLC,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_RRC,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_RAL,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_RAR,  8'h00, 1'b0, UNCHECKED},
      {accalu_pkg::KIND_CMA,  8'h00, 1'b0, UNCHECKED},
      {KIND_UNUSED_LAST, 8'h55, 1'b0, UNCHECKED}
   };

   localparam logic [accalu_pkg::KindWidth-1:0] DECIMAL_ARITH [4] =
      '{accalu_pkg::KIND_ADD, accalu_pkg::KIND_ADC, accalu_pkg::KIND_SUB, accalu_pkg::KIND_SBB};
   localparam logic [accalu_pkg::DataWidth-1:0] CORNER_BYTES [8] =
      '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h99, 8'h09};

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [accalu_pkg::KindWidth-1:0] req_kind = '0;
   logic [accalu_pkg::DataWidth-1:0] req_operand = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [accalu_pkg::DataWidth-1:0] rsp_result_value;
   logic [accalu_pkg::DataWidth-1:0] rsp_acc_out;
   logic                             rsp_sign_out;
   logic                             rsp_zero_out;
   logic                             rsp_aux_out;
   logic                             rsp_parity_out;
   logic                             rsp_carry_out;

   // Predictor state, mirroring the accumulator and flags.
   logic [accalu_pkg::DataWidth-1:0] model_acc = '0;
   accalu_pkg::flags_type            model_flags = '0;

   alu_result_type pending_results [$];
   int             mismatch_count = 0;
   int             items_sent = 0;
   int             results_checked = 0;
   int             decimal_runs = 0;
   bit             quiet_stretch = 1'b0;
   bit             kind_seen [32];

   accumulator_alu_with_flags u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_operand      (req_operand),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_sign_out     (rsp_sign_out),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_aux_out      (rsp_aux_out),
      .rsp_parity_out   (rsp_parity_out),
      .rsp_carry_out    (rsp_carry_out)
   );

   always #2 clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // Applies one operation to the predictor state and returns the result item.
   function automatic alu_result_type alu_apply(
      input logic [accalu_pkg::KindWidth-1:0] kind,
      input logic [accalu_pkg::DataWidth-1:0] operand);
      alu_result_type                   r;
      logic [accalu_pkg::DataWidth-1:0] a;
      logic [accalu_pkg::DataWidth-1:0] addend;
      logic [accalu_pkg::DataWidth-1:0] produced;
      logic [accalu_pkg::DataWidth-1:0] szp_byte;
      logic [accalu_pkg::DataWidth:0]   sum;
      logic [4:0]                       low_sum;
      logic                             cin;
      logic                             is_sub;
      logic                             cy;
      logic                             side;
      logic                             szp_update;
      a          = model_acc;
      produced   = '0;
      szp_byte   = '0;
      side       = 1'b0;
      szp_update = 1'b0;
      case (kind)
         accalu_pkg::KIND_ADD, accalu_pkg::KIND_ADC, accalu_pkg::KIND_SUB,
         accalu_pkg::KIND_SBB, accalu_pkg::KIND_CMP: begin
            // Subtraction adds the complement with the borrow inverted; carry is a borrow.
            is_sub  = (kind == accalu_pkg::KIND_SUB) || (kind == accalu_pkg::KIND_SBB) ||
                      (kind == accalu_pkg::KIND_CMP);
            cin     = (kind == accalu_pkg::KIND_ADC || kind == accalu_pkg::KIND_SBB) ?
                      model_flags.carry : 1'b0;
            cin     = cin ^ is_sub;
            addend  = is_sub ? ~operand : operand;
            sum     = {1'b0, a} + {1'b0, addend} + cin;
            low_sum = {1'b0, a[3:0]} + {1'b0, addend[3:0]} + cin;
            model_flags.carry = sum[accalu_pkg::DataWidth] ^ is_sub;
            model_flags.aux   = low_sum[4];
            szp_byte   = sum[accalu_pkg::DataWidth-1:0];
            szp_update = 1'b1;
            if (kind != accalu_pkg::KIND_CMP) begin
               model_acc = sum[accalu_pkg::DataWidth-1:0];
            end
         end
         accalu_pkg::KIND_AND: begin
            model_acc         = a & operand;
            model_flags.carry = 1'b0;
            model_flags.aux   = a[3] | operand[3];
            szp_byte   = model_acc;
            szp_update = 1'b1;
         end
         accalu_pkg::KIND_XOR, accalu_pkg::KIND_OR: begin
            model_acc         = (kind == accalu_pkg::KIND_XOR) ? (a ^ operand) : (a | operand);
            model_flags.carry = 1'b0;
            model_flags.aux   = 1'b0;
            szp_byte   = model_acc;
            szp_update = 1'b1;
         end
         accalu_pkg::KIND_INR: begin
            produced        = operand + 8'd1;
            model_flags.aux = (produced[3:0] == 4'd0);
            szp_byte   = produced;
            szp_update = 1'b1;
            side       = 1'b1;
         end
         accalu_pkg::KIND_DCR: begin
            produced        = operand - 8'd1;
            model_flags.aux = (operand[3:0] != 4'd0);
            szp_byte   = produced;
            szp_update = 1'b1;
            side       = 1'b1;
         end
         accalu_pkg::KIND_DAA: begin
            // Decimal adjust: carry may be set here but is never cleared.
            addend = '0;
            cy     = model_flags.carry;
            if (model_flags.aux || a[3:0] > accalu_pkg::DAA_DIGIT_MAX) begin
               addend = addend | accalu_pkg::DAA_LOW_CORR;
            end
            if (cy || a[7:4] > accalu_pkg::DAA_DIGIT_MAX ||
                (a[7:4] >= accalu_pkg::DAA_DIGIT_MAX && a[3:0] > accalu_pkg::DAA_DIGIT_MAX)) begin
               addend = addend | accalu_pkg::DAA_HIGH_CORR;
               cy     = 1'b1;
            end
            sum     = {1'b0, a} + {1'b0, addend};
            low_sum = {1'b0, a[3:0]} + {1'b0, addend[3:0]};
            model_acc         = sum[accalu_pkg::DataWidth-1:0];
            model_flags.aux   = low_sum[4];
            model_flags.carry = cy;
            szp_byte   = model_acc;
            szp_update = 1'b1;
         end
         accalu_pkg::KIND_RLC: begin
            model_flags.carry = a[7];
            model_acc         = {a[6:0], a[7]};
         end
         accalu_pkg::KIND_RRC: begin
            model_flags.carry = a[0];
            model_acc         = {a[0], a[7:1]};
         end
         accalu_pkg::KIND_RAL: begin
            model_acc         = {a[6:0], model_flags.carry};
            model_flags.carry = a[7];
         end
         accalu_pkg::KIND_RAR: begin
            model_acc         = {model_flags.carry, a[7:1]};
            model_flags.carry = a[0];
         end
         accalu_pkg::KIND_CMA:  model_acc = ~a;
         accalu_pkg::KIND_CMC:  model_flags.carry = ~model_flags.carry;
         accalu_pkg::KIND_STC:  model_flags.carry = 1'b1;
         accalu_pkg::KIND_LOAD: model_acc = operand;
         default: begin
         end
      endcase
      if (szp_update) begin
         model_flags.sign   = szp_byte[7];
         model_flags.zero   = (szp_byte == '0);
         model_flags.parity = ~^szp_byte;
      end
      r.value = side ? produced : model_acc;
      r.acc   = model_acc;
      r.flags = model_flags;
      return r;
   endfunction

   // Offers one item, waits for it to be taken, then queues its expected result.
   task automatic send_item(input logic [accalu_pkg::KindWidth-1:0] kind,
                            input logic [accalu_pkg::DataWidth-1:0] operand,
                            input logic fixed,
                            input alu_result_type fixed_want);
      alu_result_type want;
      while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_operand <= operand;
      do @(posedge clock); while (!req_ready);
      want = alu_apply(kind, operand);
      if (fixed) begin
         want = fixed_want;
      end
      pending_results.push_back(want);
      kind_seen[kind] = 1'b1;
      items_sent++;
   endtask

   // Receiver: stalls at random except in the quiet stretch.
   always @(posedge clock) begin
      rsp_ready <= quiet_stretch || ($urandom_range(99) >= STALL_PERCENT);
   end

   // Compares each accepted result item with the oldest expectation.
   always @(posedge clock) begin : check_results
      alu_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result item with nothing expected, acc %0h",
                                      rsp_acc_out));
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_value !== want.value)
               report_mismatch($sformatf("result_value %0h, expected %0h",
                                         rsp_result_value, want.value));
            if (rsp_acc_out !== want.acc)
               report_mismatch($sformatf("acc_out %0h, expected %0h", rsp_acc_out, want.acc));
            if (rsp_sign_out !== want.flags.sign)
               report_mismatch($sformatf("sign_out %0b, expected %0b",
                                         rsp_sign_out, want.flags.sign));
            if (rsp_zero_out !== want.flags.zero)
               report_mismatch($sformatf("zero_out %0b, expected %0b",
                                         rsp_zero_out, want.flags.zero));
            if (rsp_aux_out !== want.flags.aux)
               report_mismatch($sformatf("aux_out %0b, expected %0b",
                                         rsp_aux_out, want.flags.aux));
            if (rsp_parity_out !== want.flags.parity)
               report_mismatch($sformatf("parity_out %0b, expected %0b",
                                         rsp_parity_out, want.flags.parity));
            if (rsp_carry_out !== want.flags.carry)
               report_mismatch($sformatf("carry_out %0b, expected %0b",
                                         rsp_carry_out, want.flags.carry));
         end
      end
   end

   // Main sequence: reset, directed table, random items, drain and verdict.
   initial begin : stimulus
      logic [accalu_pkg::KindWidth-1:0] kind;
      logic [accalu_pkg::DataWidth-1:0] operand;
      int                               kinds_hit;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (DIRECTED_ROWS[i]) begin
         send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].operand,
                   DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
      end

      // Random items, with decimal add and subtract sequences mixed in.
      while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
         quiet_stretch = (items_sent >= QUIET_FIRST) && (items_sent < QUIET_LAST);
         if ($urandom_range(4) == 0) begin
            decimal_runs++;
            operand = {4'($urandom_range(9)), 4'($urandom_range(9))};
            send_item(accalu_pkg::KIND_LOAD, operand, 1'b0, UNCHECKED);
            operand = {4'($urandom_range(9)), 4'($urandom_range(9))};
            send_item(DECIMAL_ARITH[$urandom_range(3)], operand, 1'b0, UNCHECKED);
            send_item(accalu_pkg::KIND_DAA, 8'($urandom_range(255)), 1'b0, UNCHECKED);
         end else begin
            if ($urandom_range(19) == 0) begin
               kind = 5'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
            end else begin
               kind = 5'($urandom_range(accalu_pkg::KIND_LOAD));
            end
            operand = 8'($urandom_range(255));
            if ($urandom_range(7) == 0) begin
               operand = CORNER_BYTES[$urandom_range(7)];
            end
            send_item(kind, operand, 1'b0, UNCHECKED);
         end
      end
      quiet_stretch = 1'b0;
      req_valid <= 1'b0;

      // Drain: wait for every expected result, then keep watching for strays.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      kinds_hit = 0;
      foreach (kind_seen[i]) begin
         if (kind_seen[i]) kinds_hit++;
      end
      $display("Summary: %0d items driven (%0d from the directed table, %0d decimal runs),",
               items_sent, NUM_DIRECTED, decimal_runs);
      $display("Summary: %0d result items checked, %0d of 32 operation codes exercised.",
               results_checked, kinds_hit);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d result items outstanding", pending_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/accalu_pkg.sv
hw/rtl/accumulator_alu_with_flags.sv
tb/tb.sv
